>>> rtl/core/ckt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ckt_pkg;

  localparam int unsigned KEY_W    = 16;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned TOTAL_W  = 5;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_SEARCH = 2'd2,
    MODE_GET    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_BAD_INDEX = 2'd3
  } status_e;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

endpackage

`default_nettype wire

>>> rtl/core/compacting_keyed_table_core.sv
//  Channel   Direction  Handshake            Words
//  command   in         start / busy         mode_i, key_i, handle_i, index_i
//  result    out        done_o (one cycle)   status_o, found_slot_o, key_out_o,
//                                             handle_out_o, entry_total_o
//
//  Steps: an add, or a command that fails at once, is decided in the
//  accepting cycle; a get reads its slot, then answers. A search or a
//  remove reads one entry per cycle from the table memory, up to the first
//  match or the count. A remove then moves each later entry down through
//  the same memory, one entry per cycle. The registered result appears in
//  the cycle after the last step; busy is high from acceptance until then.
//  Reset clears the entry count and the control and result registers; the
//  memory holds no valid bits and is never read beyond the count. The
//  receiver cannot stall the result.
`timescale 1ns / 1ps
`default_nettype none

module compacting_keyed_table_core #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start,
  output logic                             busy,
  input  ckt_pkg::mode_e                   mode_i,
  input  wire  [ckt_pkg::KEY_W-1:0]        key_i,
  input  wire  [ckt_pkg::HANDLE_W-1:0]     handle_i,
  input  wire  [ckt_pkg::INDEX_W-1:0]      index_i,
  output logic                             done_o,
  output ckt_pkg::status_e                 status_o,
  output logic [ckt_pkg::SLOT_W-1:0]       found_slot_o,
  output logic [ckt_pkg::KEY_W-1:0]        key_out_o,
  output logic [ckt_pkg::HANDLE_W-1:0]     handle_out_o,
  output logic [ckt_pkg::TOTAL_W-1:0]      entry_total_o
);

  import ckt_pkg::*;

  // CW holds a count up to TABLE_DEPTH; AW addresses one slot.
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GET,
    ST_SCAN,
    ST_SHIFT
  } state_e;

  // Result fields wrap to their port widths, as slot numbers may exceed them.
  function automatic logic [SLOT_W-1:0] to_slot(input logic [CW-1:0] v);
    logic [CW+SLOT_W-1:0] ext;
    ext = {{SLOT_W{1'b0}}, v};
    return ext[SLOT_W-1:0];
  endfunction

  function automatic logic [TOTAL_W-1:0] to_total(input logic [CW-1:0] v);
    logic [CW+TOTAL_W-1:0] ext;
    ext = {{TOTAL_W{1'b0}}, v};
    return ext[TOTAL_W-1:0];
  endfunction

  // Table memory: one entry per slot, synchronous read into rdata_q.
  entry_t          mem [TABLE_DEPTH];
  entry_t          rdata_q;
  logic [AW-1:0]   raddr;
  logic            we;
  logic [AW-1:0]   waddr;
  entry_t          wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     cur_q, cur_d;         // slot in rdata_q, or shift target
  mode_e             op_q, op_d;
  logic [KEY_W-1:0]  skey_q, skey_d;       // key being searched for
  entry_t            rm_q, rm_d;           // entry taken out by a remove
  logic [CW-1:0]     rm_slot_q, rm_slot_d;

  logic              done_q, done_d;
  status_e           status_q, status_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [KEY_W-1:0]  okey_q, okey_d;
  logic [HANDLE_W-1:0] ohandle_q, ohandle_d;
  logic [TOTAL_W-1:0]  total_q, total_d;

  logic [CW:0]         count_ext;
  logic [CW:0]         cur_p1;
  logic [CW:0]         cur_p2;
  logic [CW+INDEX_W-1:0] idx_ext;
  logic [CW+INDEX_W-1:0] cnt_idx_ext;
  logic [CW-1:0]       count_dec;
  logic                key_hit;

  assign count_ext   = {1'b0, count_q};
  assign cur_p1      = {1'b0, cur_q} + {{CW{1'b0}}, 1'b1};
  assign cur_p2      = {1'b0, cur_q} + (CW + 1)'(2);
  assign idx_ext     = {{CW{1'b0}}, index_i};
  assign cnt_idx_ext = {{INDEX_W{1'b0}}, count_q};
  assign count_dec   = count_q - {{(CW-1){1'b0}}, 1'b1};
  assign key_hit     = (rdata_q.key == skey_q);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    cur_d     = cur_q;
    op_d      = op_q;
    skey_d    = skey_q;
    rm_d      = rm_q;
    rm_slot_d = rm_slot_q;
    done_d    = 1'b0;
    status_d  = status_q;
    slot_d    = slot_q;
    okey_d    = okey_q;
    ohandle_d = ohandle_q;
    total_d   = total_q;
    raddr     = cur_q[AW-1:0];
    we        = 1'b0;
    waddr     = cur_q[AW-1:0];
    wdata     = rdata_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          // A failed command reports zeros and the unchanged count.
          status_d  = STAT_OK;
          slot_d    = '0;
          okey_d    = '0;
          ohandle_d = '0;
          total_d   = to_total(count_q);
          unique case (mode_i)
            MODE_ADD: begin
              done_d = 1'b1;
              if (count_ext < (CW + 1)'(TABLE_DEPTH)) begin
                we        = 1'b1;
                waddr     = count_q[AW-1:0];
                wdata     = '{key: key_i, handle: handle_i};
                count_d   = count_q + {{(CW-1){1'b0}}, 1'b1};
                slot_d    = to_slot(count_q);
                okey_d    = key_i;
                ohandle_d = handle_i;
                total_d   = to_total(count_q + {{(CW-1){1'b0}}, 1'b1});
              end else begin
                status_d = STAT_FULL;
              end
            end
            MODE_REMOVE, MODE_SEARCH: begin
              op_d   = mode_i;
              skey_d = key_i;
              if (count_q == '0) begin
                done_d   = 1'b1;
                status_d = STAT_NOT_FOUND;
              end else begin
                raddr   = '0;
                cur_d   = '0;
                state_d = ST_SCAN;
              end
            end
            MODE_GET: begin
              if (idx_ext < cnt_idx_ext) begin
                raddr   = idx_ext[AW-1:0];
                cur_d   = idx_ext[CW-1:0];
                state_d = ST_GET;
              end else begin
                done_d   = 1'b1;
                status_d = STAT_BAD_INDEX;
              end
            end
            default: ;
          endcase
        end
      end

      ST_GET: begin
        done_d    = 1'b1;
        slot_d    = to_slot(cur_q);
        okey_d    = rdata_q.key;
        ohandle_d = rdata_q.handle;
        state_d   = ST_IDLE;
      end

      ST_SCAN: begin
        if (key_hit) begin
          if (op_q == MODE_SEARCH) begin
            done_d    = 1'b1;
            slot_d    = to_slot(cur_q);
            okey_d    = rdata_q.key;
            ohandle_d = rdata_q.handle;
            state_d   = ST_IDLE;
          end else if (cur_p1 < count_ext) begin
            // Later entries exist: start moving them down over the hole.
            rm_d      = rdata_q;
            rm_slot_d = cur_q;
            raddr     = cur_p1[AW-1:0];
            state_d   = ST_SHIFT;
          end else begin
            done_d    = 1'b1;
            count_d   = count_dec;
            slot_d    = to_slot(cur_q);
            okey_d    = rdata_q.key;
            ohandle_d = rdata_q.handle;
            total_d   = to_total(count_dec);
            state_d   = ST_IDLE;
          end
        end else if (cur_p1 < count_ext) begin
          raddr = cur_p1[AW-1:0];
          cur_d = cur_p1[CW-1:0];
        end else begin
          done_d   = 1'b1;
          status_d = STAT_NOT_FOUND;
          state_d  = ST_IDLE;
        end
      end

      ST_SHIFT: begin
        // rdata_q holds slot cur_q + 1; it moves to slot cur_q.
        we    = 1'b1;
        waddr = cur_q[AW-1:0];
        wdata = rdata_q;
        if (cur_p2 < count_ext) begin
          raddr = cur_p2[AW-1:0];
          cur_d = cur_p1[CW-1:0];
        end else begin
          done_d    = 1'b1;
          count_d   = count_dec;
          slot_d    = to_slot(rm_slot_q);
          okey_d    = rm_q.key;
          ohandle_d = rm_q.handle;
          total_d   = to_total(count_dec);
          state_d   = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      cur_q     <= '0;
      op_q      <= MODE_ADD;
      skey_q    <= '0;
      rm_q      <= '0;
      rm_slot_q <= '0;
      done_q    <= 1'b0;
      status_q  <= STAT_OK;
      slot_q    <= '0;
      okey_q    <= '0;
      ohandle_q <= '0;
      total_q   <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      cur_q     <= cur_d;
      op_q      <= op_d;
      skey_q    <= skey_d;
      rm_q      <= rm_d;
      rm_slot_q <= rm_slot_d;
      done_q    <= done_d;
      status_q  <= status_d;
      slot_q    <= slot_d;
      okey_q    <= okey_d;
      ohandle_q <= ohandle_d;
      total_q   <= total_d;
    end
  end

  assign busy          = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign found_slot_o  = slot_q;
  assign key_out_o     = okey_q;
  assign handle_out_o  = ohandle_q;
  assign entry_total_o = total_q;

  // The count never exceeds the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_ext <= (CW + 1)'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // A scan or shift only runs over a table that holds entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_SHIFT) |-> count_q != '0)
    else $error("scan over an empty table");

  // Each command moves the count by at most one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (count_q == $past(count_q) ||
              count_q == $past(count_q) + {{(CW-1){1'b0}}, 1'b1} ||
              count_q == $past(count_q) - {{(CW-1){1'b0}}, 1'b1}))
    else $error("entry count jumped");

  // An add to a table with room answers ok in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && mode_i == MODE_ADD && count_ext < (CW + 1)'(TABLE_DEPTH))
      |=> (done_o && status_o == STAT_OK))
    else $error("add did not complete in one cycle");

  // A failed command reports zero slot, key and handle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != STAT_OK) |->
      (found_slot_o == '0 && key_out_o == '0 && handle_out_o == '0))
    else $error("failed result carries entry data");

  // The table is never busy while a result is being delivered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result delivered while busy");

endmodule

`default_nettype wire

>>> tb/sv/tb_compacting_keyed_table_core.sv
`timescale 1ns / 1ps

// Testbench for the compacting keyed table core.
//
// An initial block fills a queue of table operations. A short directed run
// covers the empty table, the full table, duplicate keys, removal at both
// ends and out-of-range reads. Random operations with a small key pool
// follow, so that removes and searches often hit.
//
// A clocked driver offers one command word at a time on start/busy. At the
// edge where a word is taken, a local copy of the table computes the result
// that the core must return, and that result is queued. A clocked monitor
// compares each result word, marked by done_o, field by field with the oldest
// queued result.
module tb_compacting_keyed_table_core;
  import ckt_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned RANDOM_OPS = 550;
  // No idle gaps on the sender side for this many final random words.
  localparam int unsigned CALM_TAIL = 60;
  // A remove on a full table is the longest command; give the end generous room.
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned CYCLE_LIMIT = 200000;

  // One queued command word together with how the driver should present it.
  typedef struct {
    mode_e             mode;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    logic [INDEX_W-1:0]  index;
    bit                  wait_empty;  // hold back until all results are in
    bit                  gaps_allowed;
  } table_op_t;

  typedef struct {
    status_e             status;
    logic [SLOT_W-1:0]   slot;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    logic [TOTAL_W-1:0]  total;
  } table_result_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  mode_e mode_i;
  logic [KEY_W-1:0] key_i;
  logic [HANDLE_W-1:0] handle_i;
  logic [INDEX_W-1:0] index_i;
  logic done_o;
  status_e status_o;
  logic [SLOT_W-1:0] found_slot_o;
  logic [KEY_W-1:0] key_out_o;
  logic [HANDLE_W-1:0] handle_out_o;
  logic [TOTAL_W-1:0] entry_total_o;

  compacting_keyed_table_core #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .mode_i       (mode_i),
    .key_i        (key_i),
    .handle_i     (handle_i),
    .index_i      (index_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .found_slot_o (found_slot_o),
    .key_out_o    (key_out_o),
    .handle_out_o (handle_out_o),
    .entry_total_o(entry_total_o)
  );

  // Pending command words, and results that the core still owes.
  table_op_t pending_ops[$];
  table_result_t owed_results[$];

  // The local copy of the table: packed from slot 0, like the core's.
  logic [KEY_W-1:0] tbl_key[DEPTH];
  logic [HANDLE_W-1:0] tbl_handle[DEPTH];
  int unsigned tbl_count;

  // Both counters change by nonblocking assignment only, so either clocked
  // block reads the values from before the edge, whatever the order in which
  // the two blocks run.
  int unsigned words_taken;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned gap_left;
  table_op_t next_op;

  logic [KEY_W-1:0] key_pool[8];

  // Applies one table operation to the local copy and returns the result
  // word that the core must produce for it.
  function automatic table_result_t apply_table_op(mode_e op, logic [KEY_W-1:0] k,
                                                   logic [HANDLE_W-1:0] h,
                                                   logic [INDEX_W-1:0] idx);
    table_result_t r;
    int hit;
    r = '{status: STAT_OK, slot: '0, key: '0, handle: '0, total: '0};
    hit = -1;
    // Remove and search act on the lowest slot holding the key.
    for (int i = 0; i < int'(tbl_count); i++) begin
      if (hit < 0 && tbl_key[i] == k) begin
        hit = i;
      end
    end
    case (op)
      MODE_ADD: begin
        if (tbl_count < DEPTH) begin
          tbl_key[tbl_count] = k;
          tbl_handle[tbl_count] = h;
          r.slot = SLOT_W'(tbl_count);
          r.key = k;
          r.handle = h;
          tbl_count++;
        end else begin
          r.status = STAT_FULL;
        end
      end
      MODE_REMOVE: begin
        if (hit >= 0) begin
          r.slot = SLOT_W'(hit);
          r.key = tbl_key[hit];
          r.handle = tbl_handle[hit];
          // Close the hole: every later entry moves down by one slot.
          for (int i = hit; i + 1 < int'(tbl_count); i++) begin
            tbl_key[i] = tbl_key[i+1];
            tbl_handle[i] = tbl_handle[i+1];
          end
          tbl_count--;
        end else begin
          r.status = STAT_NOT_FOUND;
        end
      end
      MODE_SEARCH: begin
        if (hit >= 0) begin
          r.slot = SLOT_W'(hit);
          r.key = tbl_key[hit];
          r.handle = tbl_handle[hit];
        end else begin
          r.status = STAT_NOT_FOUND;
        end
      end
      default: begin
        // Get: only slots below the count hold valid entries.
        if (idx < tbl_count) begin
          r.slot = idx;
          r.key = tbl_key[idx];
          r.handle = tbl_handle[idx];
        end else begin
          r.status = STAT_BAD_INDEX;
        end
      end
    endcase
    r.total = TOTAL_W'(tbl_count);
    return r;
  endfunction

  task automatic queue_op(mode_e op, logic [KEY_W-1:0] k, logic [HANDLE_W-1:0] h,
                          logic [INDEX_W-1:0] idx, bit wait_empty, bit gaps_allowed);
    table_op_t t;
    t.mode = op;
    t.key = k;
    t.handle = h;
    t.index = idx;
    t.wait_empty = wait_empty;
    t.gaps_allowed = gaps_allowed;
    pending_ops.push_back(t);
  endtask

  // A random key: mostly from a small pool so that lookups hit, otherwise
  // any 16-bit value so that every key bit is exercised.
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 9) < 7) begin
      return key_pool[$urandom_range(0, 7)];
    end
    return KEY_W'($urandom);
  endfunction

  // Picks an operation by weight. Fill phases favor add, drain phases favor
  // remove, so the entry count sweeps between empty and full many times.
  function automatic mode_e pick_mode(bit filling);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (filling) begin
      if (roll < 55) return MODE_ADD;
      if (roll < 70) return MODE_REMOVE;
      if (roll < 85) return MODE_SEARCH;
      return MODE_GET;
    end
    if (roll < 20) return MODE_ADD;
    if (roll < 65) return MODE_REMOVE;
    if (roll < 85) return MODE_SEARCH;
    return MODE_GET;
  endfunction

  task automatic next_result_check(table_result_t exp_r);
    if (status_o !== exp_r.status) begin
      $error("status: expected %0d, got %0d", exp_r.status, status_o);
      mismatches++;
    end
    if (found_slot_o !== exp_r.slot) begin
      $error("found_slot: expected %0d, got %0d", exp_r.slot, found_slot_o);
      mismatches++;
    end
    if (key_out_o !== exp_r.key) begin
      $error("key_out: expected %h, got %h", exp_r.key, key_out_o);
      mismatches++;
    end
    if (handle_out_o !== exp_r.handle) begin
      $error("handle_out: expected %h, got %h", exp_r.handle, handle_out_o);
      mismatches++;
    end
    if (entry_total_o !== exp_r.total) begin
      $error("entry_total: expected %0d, got %0d", exp_r.total, entry_total_o);
      mismatches++;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Sender side. A word stays on the ports while busy is high; at the edge
  // that takes it, its result is predicted and owed. Each signal gets one
  // nonblocking assignment per edge, so a word that follows directly keeps
  // start high without a glitch.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        owed_results.push_back(apply_table_op(mode_i, key_i, handle_i, index_i));
        words_taken <= words_taken + 1;
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pending_ops.size() == 0) begin
          start <= 1'b0;
        end else if (pending_ops[0].wait_empty && (start || words_taken != results_seen)) begin
          // Hold the next word until the core has returned every result.
          start <= 1'b0;
        end else if (pending_ops[0].gaps_allowed && $urandom_range(0, 3) == 0) begin
          // Start an idle burst that includes this cycle; gap_left holds the rest.
          gap_left <= $urandom_range(0, 2);
          start <= 1'b0;
        end else begin
          next_op = pending_ops.pop_front();
          mode_i <= next_op.mode;
          key_i <= next_op.key;
          handle_i <= next_op.handle;
          index_i <= next_op.index;
          start <= 1'b1;
        end
      end
    end
  end

  // Receiver side. The core cannot be stalled, so every done_o cycle is
  // checked against the oldest owed result.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (results_seen == words_taken) begin
        $error("result word with none owed: status %0d slot %0d total %0d",
               status_o, found_slot_o, entry_total_o);
        mismatches++;
      end else begin
        next_result_check(owed_results.pop_front());
        results_seen <= results_seen + 1;
      end
    end
  end

  // Watchdog for a core that hangs or never raises done_o.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_compacting_keyed_table_core NOT OK");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    mode_i = MODE_ADD;
    key_i = '0;
    handle_i = '0;
    index_i = '0;
    tbl_count = 0;
    words_taken = 0;
    results_seen = 0;
    mismatches = 0;
    cycle_count = 0;
    gap_left = 0;
    key_pool = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                 16'h5A5A, 16'hA5A5, 16'h1234, 16'h7FFF};

    // Directed part. On the empty table every lookup must fail.
    queue_op(MODE_GET, '0, '0, 4'd0, 1'b0, 1'b1);
    queue_op(MODE_REMOVE, 16'h0000, '0, '0, 1'b0, 1'b1);
    queue_op(MODE_SEARCH, 16'hFFFF, '0, 4'd15, 1'b0, 1'b1);
    // Fill every slot: extreme keys and handles first, then a duplicate key.
    queue_op(MODE_ADD, 16'h0000, 16'hFFFF, 4'd15, 1'b0, 1'b1);
    queue_op(MODE_ADD, 16'hFFFF, 16'h0000, '0, 1'b0, 1'b1);
    queue_op(MODE_ADD, 16'h0000, 16'h1234, '0, 1'b0, 1'b1);
    for (int i = 3; i < DEPTH; i++) begin
      queue_op(MODE_ADD, KEY_W'(16'h1000 + i), HANDLE_W'(16'hC000 + i), '0, 1'b0, 1'b1);
    end
    // A full table refuses an add; the last slot is readable.
    queue_op(MODE_ADD, 16'h4444, 16'h4444, '0, 1'b0, 1'b1);
    queue_op(MODE_GET, '0, '0, 4'd15, 1'b0, 1'b1);
    // Duplicate keys: search and remove take the lowest slot, after which
    // the second copy has moved down and is found next.
    queue_op(MODE_SEARCH, 16'h0000, '0, '0, 1'b0, 1'b1);
    queue_op(MODE_REMOVE, 16'h0000, '0, '0, 1'b0, 1'b1);
    queue_op(MODE_SEARCH, 16'h0000, '0, '0, 1'b0, 1'b1);
    // Remove the entry in the last slot, then read at the count.
    queue_op(MODE_REMOVE, KEY_W'(16'h1000 + DEPTH - 1), '0, '0, 1'b0, 1'b1);
    queue_op(MODE_GET, '0, '0, 4'd14, 1'b0, 1'b1);

    // Random part, in phases of 50 words. Idle gaps come in stretches and
    // stop for the final words; twice the sender waits for an empty pipe.
    for (int n = 0; n < RANDOM_OPS; n++) begin
      queue_op(pick_mode(((n / 50) % 2) == 0), pick_key(), HANDLE_W'($urandom),
               INDEX_W'($urandom_range(0, 15)), (n == 150 || n == 400),
               (n < RANDOM_OPS - CALM_TAIL) && ((n / 30) % 3 != 2));
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_ops.size() != 0 || start || words_taken != results_seen) begin
      @(posedge clk_i);
    end
    // Any stray result word would show up within this window.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && words_taken == results_seen) begin
      $display("tb_compacting_keyed_table_core OK");
    end else begin
      $display("tb_compacting_keyed_table_core NOT OK");
    end
    $finish;
  end

endmodule
